@@ hdl/chmn_pkg.sv @@
// Shared constants for the per-channel max normalizer.
// No dependencies; used by the top level and its checker.
package chmn_pkg;

  localparam int CHANNEL_BITS = 16;
  localparam int LANES        = 4;
  localparam int DATA_W       = LANES * CHANNEL_BITS;
  localparam int USER_W       = 2;
  localparam int CNT_W        = $clog2(CHANNEL_BITS);

  // tuser bit positions on the input side
  localparam int USER_OP    = 0;
  localparam int USER_FIRST = 1;

  localparam logic [CHANNEL_BITS-1:0] FULL = {CHANNEL_BITS{1'b1}};

  typedef logic [CHANNEL_BITS-1:0] chan_t;

endpackage

@@ hdl/channel_max_normalize_top.sv @@
// Per-channel max normalizer: measure beats track four channel peaks,
// normalize beats divide each channel by its peak. Depends on chmn_pkg.
// Sequence: a measure beat returns no result; a normalize beat goes
//   through one set-up state, then the four restoring divider lanes make
//   one quotient bit per cycle, then a done state loads the output register.
// Throughput: no new beat is taken until a normalize beat's result is
//   loaded into the output register, which waits while a result beat
//   stalls; one measure beat per cycle while no normalize beat is in flight.
// Reset: rst_n synchronous, clears all peaks to zero and empties the output.
module channel_max_normalize_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // fields from bit 0: red_in, green_in, blue_in, alpha_in
  input  logic [chmn_pkg::DATA_W-1:0] in_tdata,
  // fields from bit 0: operation, first_of_image
  input  logic [chmn_pkg::USER_W-1:0] in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // fields from bit 0: red_out, green_out, blue_out, alpha_out
  output logic [chmn_pkg::DATA_W-1:0] out_tdata
);
  import chmn_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  chan_t peak_r [LANES];
  chan_t peak_nxt [LANES];
  chan_t smp_r [LANES];
  chan_t smp_nxt [LANES];
  chan_t rem_r [LANES];
  chan_t rem_nxt [LANES];
  chan_t dvd_r [LANES];
  chan_t dvd_nxt [LANES];
  chan_t quo_r [LANES];
  chan_t quo_nxt [LANES];
  logic [LANES-1:0] zero_r, zero_nxt;
  logic [LANES-1:0] sat_r, sat_nxt;

  logic              out_tvalid_r, out_tvalid_nxt;
  logic [DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic in_beat;
  logic out_free;
  logic [2*CHANNEL_BITS-1:0] prod;
  logic [CHANNEL_BITS:0]     trial;
  logic [CHANNEL_BITS:0]     diff;
  chan_t                     res;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_beat    = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    zero_nxt       = zero_r;
    sat_nxt        = sat_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    prod           = '0;
    trial          = '0;
    diff           = '0;
    res            = '0;
    for (int i = 0; i < LANES; i++) begin
      peak_nxt[i] = peak_r[i];
      smp_nxt[i]  = smp_r[i];
      rem_nxt[i]  = rem_r[i];
      dvd_nxt[i]  = dvd_r[i];
      quo_nxt[i]  = quo_r[i];
    end

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          for (int i = 0; i < LANES; i++) begin
            smp_nxt[i] = in_tdata[i*CHANNEL_BITS +: CHANNEL_BITS];
            if (!in_tuser[USER_OP] &&
                (in_tuser[USER_FIRST] || smp_nxt[i] > peak_r[i])) begin
              peak_nxt[i] = smp_nxt[i];
            end
          end
          if (in_tuser[USER_OP]) begin
            state_nxt = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        // form sample * FULL as (sample << CHANNEL_BITS) - sample
        for (int i = 0; i < LANES; i++) begin
          prod        = {smp_r[i], {CHANNEL_BITS{1'b0}}} - {{CHANNEL_BITS{1'b0}}, smp_r[i]};
          rem_nxt[i]  = prod[2*CHANNEL_BITS-1:CHANNEL_BITS];
          dvd_nxt[i]  = prod[CHANNEL_BITS-1:0];
          quo_nxt[i]  = '0;
          zero_nxt[i] = (peak_r[i] == '0);
          sat_nxt[i]  = (smp_r[i] >= peak_r[i]);
        end
        cnt_nxt   = CNT_W'(CHANNEL_BITS - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // one restoring step per lane: shift in a dividend bit, try subtract
        for (int i = 0; i < LANES; i++) begin
          trial = {rem_r[i], dvd_r[i][CHANNEL_BITS-1]};
          diff  = trial - {1'b0, peak_r[i]};
          if (!diff[CHANNEL_BITS]) begin
            rem_nxt[i] = diff[CHANNEL_BITS-1:0];
          end else begin
            rem_nxt[i] = trial[CHANNEL_BITS-1:0];
          end
          dvd_nxt[i] = {dvd_r[i][CHANNEL_BITS-2:0], 1'b0};
          quo_nxt[i] = {quo_r[i][CHANNEL_BITS-2:0], !diff[CHANNEL_BITS]};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold the quotients until the output register frees up
        if (out_free) begin
          for (int i = 0; i < LANES; i++) begin
            if (zero_r[i]) begin
              res = '0;
            end else if (sat_r[i]) begin
              res = FULL;
            end else begin
              res = quo_r[i];
            end
            out_tdata_nxt[i*CHANNEL_BITS +: CHANNEL_BITS] = res;
          end
          out_tvalid_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < LANES; i++) begin
        peak_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      for (int i = 0; i < LANES; i++) begin
        peak_r[i] <= peak_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    zero_r      <= zero_nxt;
    sat_r       <= sat_nxt;
    for (int i = 0; i < LANES; i++) begin
      smp_r[i] <= smp_nxt[i];
      rem_r[i] <= rem_nxt[i];
      dvd_r[i] <= dvd_nxt[i];
      quo_r[i] <= quo_nxt[i];
    end
  end

endmodule

@@ hdl/chmn_checker.sv @@
// Port-level checks for channel_max_normalize_top, bound to the top level.
// Depends on chmn_pkg.
module chmn_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic [chmn_pkg::USER_W-1:0] in_tuser,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [chmn_pkg::DATA_W-1:0] out_tdata
);
  import chmn_pkg::*;

  // a stalled result beat holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // a normalize beat occupies the dividers
  a_norm_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[USER_OP] |=> !in_tready)
    else $error("input taken during divide");

  // a measure beat never blocks the next one
  a_meas_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser[USER_OP] |=> in_tready)
    else $error("measure beat stalled input");

  // a fresh result comes out of a busy divide
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result beat without a divide");

endmodule

bind channel_max_normalize_top chmn_checker u_chmn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
